FILE: rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Holds the channel payload structs, the group record that passes from the
// decode stage to the output buffer, and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned COUNT_BITS_DEF   = 32;
    localparam int unsigned GROUP_FIFO_DEPTH = 4;
    localparam int unsigned GROUP_BYTES      = 3;
    localparam logic [31:0] MAX_OUT_RESET    = 32'hFFFF_FFFF;
    localparam logic [7:0]  PAD_CODE         = 8'h3D;

    localparam logic [5:0] LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_BASE = 6'd52;
    localparam logic [5:0] PLUS_VALUE = 6'd62;
    localparam logic [5:0] SLASH_VALUE = 6'd63;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_error;
        logic       end_of_message;
    } out_item_t;

    // Up to three results caused by one character; res[0] goes out first.
    typedef struct packed {
        out_item_t [GROUP_BYTES-1:0] res;
        logic [1:0]                  count;
    } group_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            s.value = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            s.value = 6'(c - 8'h61) + LOWER_BASE;
        end else if (c inside {[8'h30:8'h39]}) begin
            s.value = 6'(c - 8'h30) + DIGIT_BASE;
        end else if (c == 8'h2B) begin
            s.value = PLUS_VALUE;
        end else if (c == 8'h2F) begin
            s.value = SLASH_VALUE;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: rtl/core/b64d_core.sv
// ----------------------------------------------------------------------------
// b64d_core: group assembly and decode
// Keeps the per-message state and turns one registered character into zero
// to three results in a single pass of logic.
// ----------------------------------------------------------------------------
module b64d_core #(
    parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  b64d_pkg::in_item_t item,
    input  logic [31:0]        max_out_bytes,
    output b64d_pkg::group_t   grp
);
    import b64d_pkg::*;

    localparam int unsigned LIM_W = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

    logic [17:0]           sextet_reg, sextet_next;
    logic [1:0]            pos_reg, pos_next;
    logic                  third_pad_reg, third_pad_next;
    logic                  group_bad_reg, group_bad_next;
    logic [COUNT_BITS-1:0] bytes_reg, bytes_next;
    logic                  discard_reg, discard_next;

    sextet_t     sx;
    logic        is_pad;
    logic        bad;
    logic [1:0]  nbytes;
    logic [23:0] triple;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] max_ext;
    logic [LIM_W-1:0] mask_ext;
    logic [LIM_W-1:0] sum_ext;
    logic        overflow;
    out_item_t   err_item;

    assign sx       = sextet_of(item.char_code);
    assign is_pad   = (item.char_code == PAD_CODE);
    assign err_item = '{data_byte: 8'h00, is_error: 1'b1, end_of_message: 1'b1};

    assign bad = group_bad_reg || (!is_pad && !sx.valid) || (third_pad_reg && !is_pad)
               || (is_pad && !item.last_char);
    assign nbytes = 2'd3 - {1'b0, is_pad} - {1'b0, third_pad_reg};
    assign triple = {sextet_reg, (is_pad ? 6'd0 : sx.value)};

    // The limit is the register value, clipped to what the byte counter holds.
    assign max_ext  = LIM_W'(max_out_bytes);
    assign mask_ext = LIM_W'({COUNT_BITS{1'b1}});
    assign limit    = (max_ext > mask_ext) ? mask_ext : max_ext;
    assign sum_ext  = LIM_W'(bytes_reg) + LIM_W'(nbytes);
    assign overflow = sum_ext > limit;

    always_comb begin
        sextet_next    = sextet_reg;
        pos_next       = pos_reg;
        third_pad_next = third_pad_reg;
        group_bad_next = group_bad_reg;
        bytes_next     = bytes_reg;
        discard_next   = discard_reg;
        grp            = '0;

        if (item_valid) begin
            if (discard_reg) begin
                if (item.last_char) begin
                    discard_next = 1'b0;
                    bytes_next   = '0;
                end
            end else if (pos_reg != 2'd3) begin
                if (pos_reg == 2'd2 && is_pad) begin
                    third_pad_next = 1'b1;
                end else if (!sx.valid) begin
                    group_bad_next = 1'b1;
                end else begin
                    case (pos_reg)
                        2'd0:    sextet_next = sextet_reg | {sx.value, 12'd0};
                        2'd1:    sextet_next = sextet_reg | {6'd0, sx.value, 6'd0};
                        default: sextet_next = sextet_reg | {12'd0, sx.value};
                    endcase
                end
                pos_next = pos_reg + 2'd1;
                // A message that ends inside a group is short.
                if (item.last_char) begin
                    grp.res[0]     = err_item;
                    grp.count      = 2'd1;
                    sextet_next    = '0;
                    pos_next       = '0;
                    third_pad_next = 1'b0;
                    group_bad_next = 1'b0;
                    bytes_next     = '0;
                end
            end else begin
                sextet_next    = '0;
                pos_next       = '0;
                third_pad_next = 1'b0;
                group_bad_next = 1'b0;
                if (bad || overflow) begin
                    grp.res[0]   = err_item;
                    grp.count    = 2'd1;
                    discard_next = !item.last_char;
                    if (item.last_char) begin
                        bytes_next = '0;
                    end
                end else begin
                    grp.count = nbytes;
                    grp.res[0].data_byte = triple[23:16];
                    grp.res[1].data_byte = triple[15:8];
                    grp.res[2].data_byte = triple[7:0];
                    case (nbytes)
                        2'd1:    grp.res[0].end_of_message = item.last_char;
                        2'd2:    grp.res[1].end_of_message = item.last_char;
                        default: grp.res[2].end_of_message = item.last_char;
                    endcase
                    bytes_next = item.last_char ? '0 : bytes_reg + COUNT_BITS'(nbytes);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sextet_reg    <= '0;
            pos_reg       <= '0;
            third_pad_reg <= 1'b0;
            group_bad_reg <= 1'b0;
            bytes_reg     <= '0;
            discard_reg   <= 1'b0;
        end else begin
            sextet_reg    <= sextet_next;
            pos_reg       <= pos_next;
            third_pad_reg <= third_pad_next;
            group_bad_reg <= group_bad_next;
            bytes_reg     <= bytes_next;
            discard_reg   <= discard_next;
        end
    end

endmodule

FILE: rtl/core/b64d_out_fifo.sv
// ----------------------------------------------------------------------------
// b64d_out_fifo: result buffer
// Stores whole groups of results and hands them out one result per transfer.
// ----------------------------------------------------------------------------
module b64d_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  b64d_pkg::group_t    wr_group,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output b64d_pkg::out_item_t m_data
);
    import b64d_pkg::*;

    localparam int unsigned PTR_W  = $clog2(GROUP_FIFO_DEPTH);
    localparam int unsigned FILL_W = $clog2(GROUP_FIFO_DEPTH + 1);

    group_t             entries_reg [GROUP_FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [1:0]         idx_reg, idx_next;
    group_t             head;
    logic               push;
    logic               pop;
    logic               take;

    assign head    = entries_reg[rd_ptr_reg];
    assign full    = (fill_reg == FILL_W'(GROUP_FIFO_DEPTH));
    assign m_valid = (fill_reg != '0);
    assign m_data  = head.res[idx_reg];

    assign push = wr_en && (wr_group.count != 2'd0);
    assign take = m_valid && m_ready;
    assign pop  = take && (idx_reg == 2'(head.count - 2'd1));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + FILL_W'(push) - FILL_W'(pop);
        if (pop) begin
            idx_next = 2'd0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end else begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= wr_group;
        end
    end

endmodule

FILE: rtl/core/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder, standard alphabet
// Input: one character per s_ transfer, with last_char on the final one of a
// message. Output: one decoded byte or one error result per m_ transfer;
// end_of_message marks the final byte and every error result.
// A character is registered, decoded in one pass together with the group
// state, and the zero to three results it causes are written as one group
// into a four-group output buffer. The first result of a group is shown on
// m_ after the character that completes the group has passed the input
// register and the group has reached the head of the output buffer.
// The block takes one character per cycle while the output buffer has a free
// group slot; with m_ready high that holds indefinitely, as four characters
// yield at most three bytes. When the receiver stalls, the buffer fills up to
// four groups; the next character is then held in the input register and
// s_ready stays low until the last result of the oldest group has left.
// Reset (aresetn low, synchronous) empties the buffer, clears the message
// state and sets max_out_bytes to all ones. A cfg_wr_en write takes effect
// for the next character decoded; write it only between messages.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64d_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64d_pkg::out_item_t m_data
);
    import b64d_pkg::*;

    logic [31:0] max_out_reg, max_out_next;
    logic        in_valid_reg, in_valid_next;
    in_item_t    in_data_reg;
    logic        fifo_full;
    logic        consume;
    group_t      grp;

    assign consume = in_valid_reg && !fifo_full;
    assign s_ready = !in_valid_reg || !fifo_full;

    always_comb begin
        max_out_next  = cfg_wr_en ? cfg_wr_data : max_out_reg;
        in_valid_next = (s_valid && s_ready) ? 1'b1 : (consume ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_out_reg  <= MAX_OUT_RESET;
            in_valid_reg <= 1'b0;
        end else begin
            max_out_reg  <= max_out_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    b64d_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (consume),
        .item         (in_data_reg),
        .max_out_bytes(max_out_reg),
        .grp          (grp)
    );

    b64d_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (consume),
        .wr_group(grp),
        .full    (fifo_full),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/core/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker: port-level checks for the base64 stream decoder
// Watches both channels and reset behavior from the top-level ports.
// ----------------------------------------------------------------------------
module b64d_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input b64d_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input b64d_pkg::out_item_t m_data
);
    import b64d_pkg::*;

    // A stalled result keeps its value until the transfer.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // An error result carries a zero byte and closes the message.
    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_error |-> m_data.data_byte == 8'h00 && m_data.end_of_message)
        else $error("malformed error result");

    // Reset empties the result buffer.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A stalled character keeps its value until the transfer.
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("character changed while stalled");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
